// File: hdl/pursuit_velocity_controller_core_assert.svh
// assertion macros for the pursuit velocity controller
`ifndef PURSUIT_VELOCITY_CONTROLLER_CORE_ASSERT_SVH
`define PURSUIT_VELOCITY_CONTROLLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PVC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PVC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PVC_ASSERT_IMPL(lbl, ante, cons)
`define PVC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/pvc_pkg.sv
// shared types, constants and tables for the pursuit velocity controller
`timescale 1ns / 1ps
package pvc_pkg;
    localparam int XY_W       = 33;
    localparam int Z_W        = 24;
    localparam int ATAN_IDX_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int YAW_W      = 19;
    localparam int DIST_W     = 21;
    localparam int MAG_W      = 31;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [Z_W-1:0] ANG_PI = 24'sd3294199;
    localparam logic [29:0] INV_K = 30'd652032874;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_YAW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DISTANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGULAR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_THRESH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_THRESH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_FACTOR   = 3'd6;

    localparam logic [15:0] RST_GAIN_YAW      = 16'd11469;
    localparam logic [15:0] RST_GAIN_DISTANCE = 16'd11469;
    localparam logic [16:0] RST_MAX_LINEAR    = 17'd2048;
    localparam logic [16:0] RST_MAX_ANGULAR   = 17'd4096;
    localparam logic [16:0] RST_UPPER_THRESH  = 17'd614;
    localparam logic [16:0] RST_LOWER_THRESH  = 17'd410;
    localparam logic [15:0] RST_SLOW_FACTOR   = 16'd32768;

    typedef struct packed {
        logic [15:0] gain_yaw;
        logic [15:0] gain_distance;
        logic [16:0] max_linear;
        logic [16:0] max_angular;
        logic [16:0] upper_threshold;
        logic [16:0] lower_threshold;
        logic [15:0] slow_factor;
    } cfg_t;

    // pre-rotated cordic start vector
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } item_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

    function automatic logic [Z_W-1:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
        logic [Z_W-1:0] r;
        unique case (idx)
            5'd0:  r = 24'd823550;
            5'd1:  r = 24'd486170;
            5'd2:  r = 24'd256879;
            5'd3:  r = 24'd130396;
            5'd4:  r = 24'd65451;
            5'd5:  r = 24'd32757;
            5'd6:  r = 24'd16383;
            5'd7:  r = 24'd8192;
            5'd8:  r = 24'd4096;
            5'd9:  r = 24'd2048;
            5'd10: r = 24'd1024;
            5'd11: r = 24'd512;
            5'd12: r = 24'd256;
            5'd13: r = 24'd128;
            5'd14: r = 24'd64;
            5'd15: r = 24'd32;
            5'd16: r = 24'd16;
            5'd17: r = 24'd8;
            5'd18: r = 24'd4;
            5'd19: r = 24'd2;
            5'd20: r = 24'd1;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

// File: hdl/pvc_if.sv
// valid/ready channel interfaces for target positions and velocity commands
`timescale 1ns / 1ps
interface pvc_in_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    modport source (output valid, found, pos_x, pos_y, input ready);
    modport sink (input valid, found, pos_x, pos_y, output ready);
endinterface

interface pvc_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] angular_rate;
    logic [16:0]        linear_speed;
    modport source (output valid, angular_rate, linear_speed, input ready);
    modport sink (input valid, angular_rate, linear_speed, output ready);
endinterface

// File: hdl/pvc_front.sv
// front end: takes position items, drops unfound ones, pre-rotates into the right half plane
`timescale 1ns / 1ps
module pvc_front (
    input  logic           clk,
    input  logic           rst_n,
    pvc_in_if.sink         in_ch,
    output logic           push,
    input  logic           q_ready,
    output pvc_pkg::item_t push_item
);
    import pvc_pkg::*;

    logic  stage_valid_reg, stage_valid_next;
    item_t stage_item_reg, stage_item_next;
    logic  accept;

    assign in_ch.ready = !stage_valid_reg || q_ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign push        = stage_valid_reg && q_ready;
    assign push_item   = stage_item_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_item_next  = stage_item_reg;
        if (push)
        begin
            stage_valid_next = 1'b0;
        end
        if (accept)
        begin
            stage_valid_next = in_ch.found;
            // negative x: rotate by pi so cordic converges
            if (in_ch.pos_x[15])
            begin
                stage_item_next.x = -$signed({{(XY_W-30){in_ch.pos_x[15]}}, in_ch.pos_x, 14'b0});
                stage_item_next.y = -$signed({{(XY_W-30){in_ch.pos_y[15]}}, in_ch.pos_y, 14'b0});
                stage_item_next.z = in_ch.pos_y[15] ? -ANG_PI : ANG_PI;
            end
            else
            begin
                stage_item_next.x = $signed({{(XY_W-30){in_ch.pos_x[15]}}, in_ch.pos_x, 14'b0});
                stage_item_next.y = $signed({{(XY_W-30){in_ch.pos_y[15]}}, in_ch.pos_y, 14'b0});
                stage_item_next.z = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_item_reg <= stage_item_next;
    end
endmodule

// File: hdl/pvc_queue.sv
// two-entry queue between front end and cordic back end
`timescale 1ns / 1ps
module pvc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pvc_pkg::item_t push_item,
    output logic           q_ready,
    input  logic           pop,
    output logic           q_valid,
    output pvc_pkg::item_t pop_item
);
    import pvc_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_ready  = count_reg != 2'd2;
    assign q_valid  = count_reg != 2'd0;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

// File: hdl/pvc_back.sv
// back end: iterative cordic, gain scaling, band decision and output register
`timescale 1ns / 1ps
`include "pursuit_velocity_controller_core_assert.svh"
module pvc_back #(
    parameter int CORDIC_STEPS = pvc_pkg::CORDIC_STEPS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pvc_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  pvc_pkg::item_t pop_item,
    output logic           pop,
    pvc_out_if.source      out_ch
);
    import pvc_pkg::*;

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ITER = 3'd1;
    localparam logic [2:0] ST_MAG  = 3'd2;
    localparam logic [2:0] ST_DIST = 3'd3;
    localparam logic [2:0] ST_SLOW = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [MAG_W-1:0]       mag_reg, mag_next;
    logic signed [YAW_W-1:0] yaw_reg, yaw_next;
    logic [DIST_W-1:0]      dist_reg, dist_next;
    logic [16:0]            slow_reg, slow_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [17:0]     ang_reg, ang_next;
    logic [16:0]            lin_reg, lin_next;

    logic signed [XY_W-1:0] xs, ys;
    logic [Z_W-1:0]         atan_val;
    logic [MAG_W-1:0]       x_pos;
    logic [60:0]            mag_prod;
    logic signed [40:0]     yaw_prod;
    logic [46:0]            dist_prod;
    logic [33:0]            slow_prod;
    logic                   load_out;
    logic                   band_pursuit, band_slow;
    logic signed [YAW_W-1:0] max_ang_s;
    logic [DIST_W-1:0]      up_ext, lo_ext;

    assign xs       = x_reg >>> cnt_reg;
    assign ys       = y_reg >>> cnt_reg;
    assign atan_val = atan_lookup(ATAN_IDX_W'(cnt_reg));
    assign x_pos    = x_reg[XY_W-1] ? '0 : x_reg[MAG_W-1:0];
    assign mag_prod = 61'(x_pos) * 61'(INV_K);
    assign yaw_prod = 41'(z_reg) * $signed({24'b0, cfg.gain_yaw}) + 41'sd2097152;
    assign dist_prod = 47'(mag_reg) * 47'(cfg.gain_distance) + 47'd33554432;
    assign slow_prod = 34'(dist_reg[16:0]) * 34'(cfg.slow_factor) + 34'd32768;

    assign up_ext    = DIST_W'(cfg.upper_threshold);
    assign lo_ext    = DIST_W'(cfg.lower_threshold);
    assign max_ang_s = $signed(YAW_W'(cfg.max_angular));
    assign band_pursuit = dist_reg > up_ext;
    assign band_slow    = (dist_reg < up_ext) && (dist_reg > lo_ext);

    assign pop      = (state_reg == ST_IDLE) && q_valid;
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.angular_rate = ang_reg;
    assign out_ch.linear_speed = lin_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        mag_next   = mag_reg;
        yaw_next   = yaw_reg;
        dist_next  = dist_reg;
        slow_next  = slow_reg;
        ang_next   = ang_reg;
        lin_next   = lin_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    x_next     = pop_item.x;
                    y_next     = pop_item.y;
                    z_next     = pop_item.z;
                    cnt_next   = '0;
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                if (y_reg[XY_W-1])
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - $signed(atan_val);
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + $signed(atan_val);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                mag_next   = mag_prod[60:30];
                yaw_next   = yaw_prod[40:22];
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                dist_next  = dist_prod[46:26];
                state_next = ST_SLOW;
            end
            ST_SLOW:
            begin
                slow_next  = slow_prod[32:16];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    priority if (band_pursuit)
                    begin
                        // angular capped from above only
                        ang_next = (yaw_reg < max_ang_s) ? yaw_reg[17:0] : max_ang_s[17:0];
                        lin_next = (dist_reg < DIST_W'(cfg.max_linear)) ?
                                   dist_reg[16:0] : cfg.max_linear;
                    end
                    else if (band_slow)
                    begin
                        ang_next = yaw_reg[17:0];
                        lin_next = slow_reg;
                    end
                    else
                    begin
                        ang_next = '0;
                        lin_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        mag_reg  <= mag_next;
        yaw_reg  <= yaw_next;
        dist_reg <= dist_next;
        slow_reg <= slow_next;
        ang_reg  <= ang_next;
        lin_reg  <= lin_next;
    end

    `PVC_ASSERT_IMPL(a_pop_idle, pop, state_reg == ST_IDLE)
    `PVC_ASSERT_IMPL(a_cnt_range, state_reg == ST_ITER, cnt_reg <= LAST)
    `PVC_ASSERT_NEXT(a_out_loaded, load_out, out_valid_reg && state_reg == ST_IDLE)
endmodule

// File: hdl/pursuit_velocity_controller_core.sv
// top level of the pursuit velocity controller: config registers and datapath wiring
`timescale 1ns / 1ps
// in_ch carries found, pos_x, pos_y (signed Q5.10); out_ch carries angular_rate
// (signed Q5.12) and linear_speed (Q5.12). both are valid/ready channels.
// an item with found clear is taken and gives no result.
// the front end registers each item, pre-rotates it and pushes it into a
// two-entry queue; it keeps taking items while the back end is busy.
// the back end runs one cordic iteration per cycle on a shared add/shift unit,
// then three multiply stages and a decision state that loads the output register.
// it pops a new item from the queue only when it is back in idle, so one item
// at a time passes through the iterative cordic unit.
// the output register holds a result while out_ch.ready is low; the back end
// then waits and the queue and front fill up, after which in_ch.ready drops.
// reset clears all valid flags and loads the register defaults.
// cfg_we writes cfg_data into register cfg_index; unknown indexes are ignored.
module pursuit_velocity_controller_core #(
    parameter int CORDIC_STEPS = pvc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    pvc_in_if.sink                         in_ch,
    pvc_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [pvc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pvc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pvc_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  push, q_ready, q_valid, pop;
    item_t push_item, pop_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_YAW:      cfg_next.gain_yaw        = cfg_data[15:0];
                REG_GAIN_DISTANCE: cfg_next.gain_distance   = cfg_data[15:0];
                REG_MAX_LINEAR:    cfg_next.max_linear      = cfg_data;
                REG_MAX_ANGULAR:   cfg_next.max_angular     = cfg_data;
                REG_UPPER_THRESH:  cfg_next.upper_threshold = cfg_data;
                REG_LOWER_THRESH:  cfg_next.lower_threshold = cfg_data;
                REG_SLOW_FACTOR:   cfg_next.slow_factor     = cfg_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_yaw        <= RST_GAIN_YAW;
            cfg_reg.gain_distance   <= RST_GAIN_DISTANCE;
            cfg_reg.max_linear      <= RST_MAX_LINEAR;
            cfg_reg.max_angular     <= RST_MAX_ANGULAR;
            cfg_reg.upper_threshold <= RST_UPPER_THRESH;
            cfg_reg.lower_threshold <= RST_LOWER_THRESH;
            cfg_reg.slow_factor     <= RST_SLOW_FACTOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pvc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .push      (push),
        .q_ready   (q_ready),
        .push_item (push_item)
    );

    pvc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_item  (pop_item)
    );

    pvc_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .pop_item (pop_item),
        .pop      (pop),
        .out_ch   (out_ch)
    );
endmodule

// File: bench/pursuit_velocity_controller_core_test.sv
// testbench for the pursuit velocity controller: random positions, register sweeps
`timescale 1ns / 1ps
module pursuit_velocity_controller_core_test;
    import pvc_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam int LATENCY = STEPS + 7;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic        found;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } position_t;

    typedef struct {
        logic [17:0] angular_rate;
        logic [16:0] linear_speed;
    } command_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pvc_in_if  in_ch ();
    pvc_out_if out_ch ();

    pursuit_velocity_controller_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cfg_t      regs;
    position_t pending_positions[$];
    command_t  expected_commands[$];
    int        errors;
    longint    cycles;
    bit        send_gap_off;
    int        send_gap;
    int        recv_gap;
    int        hold_off;
    bit        recv_free;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint shift_down(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    // bearing and range by vectoring cordic, then gains and banding
    function automatic command_t velocity_command(position_t p);
        command_t c;
        longint x, y, z, xs, ys, mag, yaw, dist_err, ang, lin;
        x = longint'($signed(p.pos_x)) * 16384;
        y = longint'($signed(p.pos_y)) * 16384;
        z = 0;
        ang = 0;
        lin = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? longint'(ANG_PI) : -longint'(ANG_PI);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = shift_down(x, i);
            ys = shift_down(y, i);
            if (y < 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_lookup(i[4:0]));
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_lookup(i[4:0]));
            end
        end
        if (x < 0)
            x = 0;
        mag = (x * longint'(INV_K)) >>> 30;
        yaw = shift_down(z * longint'(regs.gain_yaw) + (longint'(1) << 21), 22);
        dist_err = (mag * longint'(regs.gain_distance) + (longint'(1) << 25)) >>> 26;
        if (dist_err > longint'(regs.upper_threshold))
        begin
            ang = (yaw < longint'(regs.max_angular)) ? yaw : longint'(regs.max_angular);
            lin = (dist_err < longint'(regs.max_linear)) ? dist_err
                                                           : longint'(regs.max_linear);
        end
        else if (dist_err < longint'(regs.upper_threshold)
                 && dist_err > longint'(regs.lower_threshold))
        begin
            ang = yaw;
            lin = (dist_err * longint'(regs.slow_factor) + 32768) >>> 16;
        end
        if (lin > 131071)
            lin = 131071;
        c.angular_rate = ang[17:0];
        c.linear_speed = lin[16:0];
        return c;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.found <= 1'b0;
            in_ch.pos_x <= '0;
            in_ch.pos_y <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                if (pending_positions[0].found)
                    expected_commands.push_back(velocity_command(pending_positions[0]));
                void'(pending_positions.pop_front());
            end
            if (in_ch.valid && !in_ch.ready)
                ;
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_positions.size() > ((in_ch.valid && in_ch.ready) ? 0 : 0)
                     && !send_gap_off)
            begin
                in_ch.valid <= 1'b1;
                in_ch.found <= pending_positions[0].found;
                in_ch.pos_x <= pending_positions[0].pos_x;
                in_ch.pos_y <= pending_positions[0].pos_y;
                send_gap <= gap_length();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_commands.size() == 0)
                begin
                    $display("%0t: unexpected item angular_rate %0d linear_speed %0d",
                             $time, $signed(out_ch.angular_rate), out_ch.linear_speed);
                    errors++;
                end
                else
                begin
                    if (out_ch.angular_rate !== expected_commands[0].angular_rate)
                    begin
                        $display("%0t: angular_rate expected %0d actual %0d", $time,
                                 $signed(expected_commands[0].angular_rate),
                                 $signed(out_ch.angular_rate));
                        errors++;
                    end
                    if (out_ch.linear_speed !== expected_commands[0].linear_speed)
                    begin
                        $display("%0t: linear_speed expected %0d actual %0d", $time,
                                 expected_commands[0].linear_speed, out_ch.linear_speed);
                        errors++;
                    end
                    void'(expected_commands.pop_front());
                end
            end
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_ch.ready <= 1'b0;
            end
            else if (recv_free)
                out_ch.ready <= 1'b1;
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                recv_gap <= gap_length();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            REG_GAIN_YAW:      regs.gain_yaw = value[15:0];
            REG_GAIN_DISTANCE: regs.gain_distance = value[15:0];
            REG_MAX_LINEAR:    regs.max_linear = value[16:0];
            REG_MAX_ANGULAR:   regs.max_angular = value[16:0];
            REG_UPPER_THRESH:  regs.upper_threshold = value[16:0];
            REG_LOWER_THRESH:  regs.lower_threshold = value[16:0];
            REG_SLOW_FACTOR:   regs.slow_factor = value[15:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_positions.size() == 0 && expected_commands.size() == 0);
        // a not-found item may still be in flight
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic add_position(input bit found, input logic [15:0] px,
                                input logic [15:0] py);
        position_t p;
        p.found = found;
        p.pos_x = px;
        p.pos_y = py;
        pending_positions.push_back(p);
    endtask

    function automatic logic [15:0] random_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 16'($signed($urandom_range(0, 600)) - 300);
        else if (r < 7)
            return 16'($signed($urandom_range(0, 4000)) - 2000);
        return 16'($urandom());
    endfunction

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++)
            add_position($urandom_range(0, 9) != 0, random_coord(), random_coord());
    endtask

    task automatic random_regs(input bit extreme);
        write_reg(REG_GAIN_YAW, extreme ? 16'hFFFF : $urandom_range(0, 65535));
        write_reg(REG_GAIN_DISTANCE, extreme ? 16'hFFFF : $urandom_range(2000, 40000));
        write_reg(REG_MAX_LINEAR, extreme ? 17'h1FFFF : $urandom_range(0, 131071));
        write_reg(REG_MAX_ANGULAR, extreme ? 0 : $urandom_range(0, 131071));
        write_reg(REG_UPPER_THRESH, extreme ? 0 : $urandom_range(0, 3000));
        write_reg(REG_LOWER_THRESH, extreme ? 17'h1FFFF : $urandom_range(0, 2000));
        write_reg(REG_SLOW_FACTOR, extreme ? 16'hFFFF : $urandom_range(0, 65535));
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_off = 0;
        recv_free = 1'b0;
        send_gap_off = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        regs = '{RST_GAIN_YAW, RST_GAIN_DISTANCE, RST_MAX_LINEAR, RST_MAX_ANGULAR,
                 RST_UPPER_THRESH, RST_LOWER_THRESH, RST_SLOW_FACTOR};
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: extremes, quadrants, origin, not found, band edges
        add_position(1, 16'h0000, 16'h0000);
        add_position(0, 16'h1234, 16'h4321);
        add_position(1, 16'h7FFF, 16'h7FFF);
        add_position(1, 16'h8000, 16'h8000);
        add_position(1, 16'h8000, 16'h0000);
        add_position(1, 16'h8000, 16'hFFFF);
        add_position(1, 16'hFFFF, 16'h0000);
        add_position(1, 16'h0000, 16'h7FFF);
        add_position(1, 16'h0000, 16'h8000);
        add_position(1, 16'h7FFF, 16'h8000);
        add_position(1, 16'd200, 16'd0);
        add_position(1, 16'd150, 16'd30);
        add_position(1, 16'd120, 16'hFFC0);
        add_position(1, 16'd100, 16'd0);
        add_position(1, 16'd50, 16'd5);
        add_position(1, 16'hFF00, 16'h0100);
        add_position(1, 16'h0400, 16'hFC00);
        drain();

        // long receiver hold-off while the sender keeps going
        hold_off = 300;
        random_phase(150);
        drain();

        random_phase(300);
        drain();

        random_regs(1'b1);
        random_phase(150);
        drain();

        // equal thresholds with zero gains
        write_reg(REG_GAIN_YAW, 0);
        write_reg(REG_GAIN_DISTANCE, 0);
        write_reg(REG_UPPER_THRESH, 0);
        write_reg(REG_LOWER_THRESH, 0);
        random_phase(60);
        drain();

        for (int k = 0; k < 5; k++)
        begin
            random_regs(1'b0);
            recv_free = (k == 2);
            random_phase(220);
            drain();
        end
        recv_free = 1'b0;
        write_reg(3'd7, 17'h1FFFF);
        random_phase(100);

        drain();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
